// ===== src/xs256_pkg.sv =====
// xs256_pkg: shared types, action codes and constants of the xoshiro256** generator.
// Used by xs256_step, xs256_scrambler and xoshiro256ss_generator. No dependencies.
`default_nettype none

package xs256_pkg;

    localparam int WORD_W  = 64;
    localparam int WORDS   = 4;
    localparam int CNT_W   = 8;
    localparam int ROT_STATE = 45;
    localparam int ROT_OUT   = 7;
    localparam int SHIFT_S1  = 17;

    typedef logic [WORDS-1:0][WORD_W-1:0] words_t;

    // Action codes of the input item
    localparam logic [1:0] ACT_NEXT      = 2'd0;
    localparam logic [1:0] ACT_SEED      = 2'd1;
    localparam logic [1:0] ACT_JUMP      = 2'd2;
    localparam logic [1:0] ACT_LONG_JUMP = 2'd3;

    // Seed mixing constants
    localparam logic [WORD_W-1:0] SEED_MIX1 = 64'h1234567890abcdef;
    localparam logic [WORD_W-1:0] SEED_MIX2 = 64'hfedcba9876543210;
    localparam logic [WORD_W-1:0] SEED_MIX3 = 64'hf0e1d2c3b4a59687;

    // Last count value of the 16 discarded seed steps
    localparam logic [CNT_W-1:0] SEED_LAST = 8'd15;
    localparam logic [CNT_W-1:0] JUMP_LAST = 8'd255;

    // Jump polynomials, word 0 in the low bits: bit n selects step n
    localparam logic [255:0] JUMP_POLY = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba};
    localparam logic [255:0] LONG_JUMP_POLY = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf};

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_JUMP,
        ST_SCR
    } fsm_t;

endpackage : xs256_pkg

`default_nettype wire

// ===== src/xs256_step.sv =====
// xs256_step: one xoshiro256 linear state step, the unit shared by all actions.
// Depends on xs256_pkg.
`default_nettype none

module xs256_step (
    input  wire xs256_pkg::words_t  cur,
    output xs256_pkg::words_t       nxt
);

    logic [xs256_pkg::WORD_W-1:0] w2a;
    logic [xs256_pkg::WORD_W-1:0] w3a;
    logic [xs256_pkg::WORD_W-1:0] sh;

    // xor network of the step
    assign sh  = cur[1] << xs256_pkg::SHIFT_S1;
    assign w2a = cur[2] ^ cur[0];
    assign w3a = cur[3] ^ cur[1];

    assign nxt[1] = cur[1] ^ w2a;
    assign nxt[0] = cur[0] ^ w3a;
    assign nxt[2] = w2a ^ sh;
    assign nxt[3] = (w3a << xs256_pkg::ROT_STATE)
                  | (w3a >> (xs256_pkg::WORD_W - xs256_pkg::ROT_STATE));

endmodule : xs256_step

`default_nettype wire

// ===== src/xs256_scrambler.sv =====
// xs256_scrambler: two-step output scrambler, rotl(s1 * 5, 7) registered, then * 9.
// Depends on xs256_pkg.
`default_nettype none

module xs256_scrambler (
    input  wire                                clk,
    input  wire                                load,
    input  wire  [xs256_pkg::WORD_W-1:0]       s1,
    output logic [xs256_pkg::WORD_W-1:0]       product
);

    logic [xs256_pkg::WORD_W-1:0] mul5;
    logic [xs256_pkg::WORD_W-1:0] rot_next;
    logic [xs256_pkg::WORD_W-1:0] rot_reg;

    // first half: times five as shift-add, then rotate
    assign mul5     = s1 + (s1 << 2);
    assign rot_next = (mul5 << xs256_pkg::ROT_OUT)
                    | (mul5 >> (xs256_pkg::WORD_W - xs256_pkg::ROT_OUT));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rot_reg <= rot_next;
        end
    end

    // second half: times nine as shift-add
    assign product = rot_reg + (rot_reg << 3);

endmodule : xs256_scrambler

`default_nettype wire

// ===== src/xoshiro256ss_generator.sv =====
// xoshiro256ss_generator: top level, sequencer, state and output register.
// Depends on xs256_pkg, xs256_step and xs256_scrambler.
//
// Usage:
//   Input channel (in_valid, in_stall, action, seed_value) takes one action per
//   transaction: next output, seed, jump or long jump. Output channel
//   (out_valid, out_stall, random_value) returns one word per next action.
//   A next action is registered in the scrambler, then moves to the output
//   register once that is free; in_stall holds off further actions until then.
//   A seed keeps in_stall high through its 16 discarded steps and a jump or long
//   jump through its 256 passes, one pass of the shared step unit per cycle.
//   A seed or jump never produces an output transaction.
//   The output register parts the channels: an action is taken while a word
//   waits, but a following next action holds in the scramble stage until the
//   output register is free, so out_stall throttles the input side.
//   Reset clears the state words to zero; until a seed arrives every output is
//   zero. The reset needs no clearing pass.
`default_nettype none

module xoshiro256ss_generator (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  [1:0]                         action,
    input  wire  [xs256_pkg::WORD_W-1:0]       seed_value,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [xs256_pkg::WORD_W-1:0]       random_value
);

    xs256_pkg::fsm_t               state_reg, state_next;
    xs256_pkg::words_t             s_reg, s_next;
    xs256_pkg::words_t             acc_reg, acc_next;
    xs256_pkg::words_t             s_step;
    logic [xs256_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                          long_reg, long_next;
    logic                          out_valid_reg, out_valid_next;
    logic [xs256_pkg::WORD_W-1:0]  out_data_reg;
    logic [xs256_pkg::WORD_W-1:0]  product;
    logic                          in_take;
    logic                          out_free;
    logic                          scr_load;
    logic                          out_load;
    logic                          poly_bit;

    // shared step unit
    xs256_step u_step (
        .cur (s_reg),
        .nxt (s_step)
    );

    // output scrambler
    xs256_scrambler u_scr (
        .clk     (clk),
        .load    (scr_load),
        .s1      (s_reg[1]),
        .product (product)
    );

    assign in_stall = (state_reg != xs256_pkg::ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign poly_bit = long_reg ? xs256_pkg::LONG_JUMP_POLY[cnt_reg]
                               : xs256_pkg::JUMP_POLY[cnt_reg];

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        long_next      = long_reg;
        scr_load       = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            xs256_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    case (action)
                        xs256_pkg::ACT_NEXT:
                        begin
                            scr_load   = 1'b1;
                            s_next     = s_step;
                            state_next = xs256_pkg::ST_SCR;
                        end
                        xs256_pkg::ACT_SEED:
                        begin
                            s_next[0]  = seed_value;
                            s_next[1]  = seed_value ^ xs256_pkg::SEED_MIX1;
                            s_next[2]  = seed_value ^ xs256_pkg::SEED_MIX2;
                            s_next[3]  = seed_value ^ xs256_pkg::SEED_MIX3;
                            cnt_next   = '0;
                            state_next = xs256_pkg::ST_SEED;
                        end
                        xs256_pkg::ACT_JUMP,
                        xs256_pkg::ACT_LONG_JUMP:
                        begin
                            acc_next   = '0;
                            cnt_next   = '0;
                            long_next  = (action == xs256_pkg::ACT_LONG_JUMP);
                            state_next = xs256_pkg::ST_JUMP;
                        end
                        default:
                        begin
                            state_next = xs256_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // discarded seed steps
            xs256_pkg::ST_SEED:
            begin
                s_next   = s_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == xs256_pkg::SEED_LAST)
                begin
                    state_next = xs256_pkg::ST_IDLE;
                end
            end

            // jump: accumulate on polynomial bit, step, last pass loads accumulator
            xs256_pkg::ST_JUMP:
            begin
                if (poly_bit)
                begin
                    acc_next = acc_reg ^ s_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == xs256_pkg::JUMP_LAST)
                begin
                    s_next     = acc_next;
                    state_next = xs256_pkg::ST_IDLE;
                end
                else
                begin
                    s_next = s_step;
                end
            end

            // finish scramble once the output register is free
            xs256_pkg::ST_SCR:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = xs256_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = xs256_pkg::ST_IDLE;
            end
        endcase
    end

    // control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xs256_pkg::ST_IDLE;
            s_reg         <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            long_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            long_reg      <= long_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= product;
        end
    end

    assign out_valid    = out_valid_reg;
    assign random_value = out_data_reg;

    // a seed transaction starts the seed run
    a_seed_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && (action == xs256_pkg::ACT_SEED) |=> state_reg == xs256_pkg::ST_SEED)
        else $error("seed did not start the seed run");

    // the seed run never passes its last count
    a_seed_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == xs256_pkg::ST_SEED |-> cnt_reg <= xs256_pkg::SEED_LAST)
        else $error("seed counter out of range");

    // a jump ends after its 256th pass
    a_jump_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == xs256_pkg::ST_JUMP && cnt_reg == xs256_pkg::JUMP_LAST
        |=> state_reg == xs256_pkg::ST_IDLE && cnt_reg == '0)
        else $error("jump did not end after 256 passes");

    // a new output word only comes out of the scramble stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !$past(out_valid_reg && out_stall)
        |-> $past(state_reg == xs256_pkg::ST_SCR))
        else $error("output word without a scramble pass");

endmodule : xoshiro256ss_generator

`default_nettype wire

// ===== tb/sv/tb_xoshiro256ss_generator.sv =====
// tb_xoshiro256ss_generator: self-checking testbench of the xoshiro256** generator.
// Depends on xs256_pkg and xoshiro256ss_generator; a built-in predictor checks
// every output word.
`default_nettype none

module tb_xoshiro256ss_generator;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transaction before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet cycles after the last word, longer than one long jump
    localparam int TAIL_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 400;
    localparam int W              = xs256_pkg::WORD_W;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [1:0]         act;
        logic [W-1:0]       seed;
        idle_mode_t         mode;
        bit                 drain_first;
    } gen_request_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic [1:0]          action       = xs256_pkg::ACT_NEXT;
    logic [W-1:0]        seed_value   = '0;
    logic                out_stall    = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [W-1:0]        random_value;

    gen_request_t        request_queue[$];
    gen_request_t        drv_req;
    logic [W-1:0]        pending_words[$];
    logic [W-1:0]        want_word;
    xs256_pkg::words_t   gen_words    = '0;
    idle_mode_t          idle_mode    = IDLE_NONE;
    int                  action_count[4];
    int                  words_checked = 0;
    int                  err_count     = 0;
    int                  quiet_cycles  = 0;

    xoshiro256ss_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .seed_value   (seed_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [W-1:0] rotl64(input logic [W-1:0] v, input int r);
        return (v << r) | (v >> (W - r));
    endfunction

    // One xoshiro256 step; returns the scrambled word of the old state
    function automatic logic [W-1:0] next_word();
        logic [W-1:0] scrambled;
        logic [W-1:0] sh;
        scrambled = rotl64(gen_words[1] * 64'd5, xs256_pkg::ROT_OUT) * 64'd9;
        sh = gen_words[1] << xs256_pkg::SHIFT_S1;
        gen_words[2] ^= gen_words[0];
        gen_words[3] ^= gen_words[1];
        gen_words[1] ^= gen_words[2];
        gen_words[0] ^= gen_words[3];
        gen_words[2] ^= sh;
        gen_words[3] = rotl64(gen_words[3], xs256_pkg::ROT_STATE);
        return scrambled;
    endfunction

    // 256 steps, accumulating the state where the polynomial bit is set
    function automatic void jump_words(input logic [255:0] poly);
        xs256_pkg::words_t acc;
        acc = '0;
        for (int n = 0; n < 256; n++)
        begin
            if (poly[n])
                acc ^= gen_words;
            void'(next_word());
        end
        gen_words = acc;
    endfunction

    function automatic void seed_words(input logic [W-1:0] s);
        gen_words[0] = s;
        gen_words[1] = s ^ xs256_pkg::SEED_MIX1;
        gen_words[2] = s ^ xs256_pkg::SEED_MIX2;
        gen_words[3] = s ^ xs256_pkg::SEED_MIX3;
        for (int n = 0; n < 16; n++)
            void'(next_word());
    endfunction

    // Update the model for one accepted transaction
    function automatic void apply_action(input logic [1:0] act, input logic [W-1:0] s);
        action_count[act]++;
        case (act)
            xs256_pkg::ACT_NEXT:      pending_words.push_back(next_word());
            xs256_pkg::ACT_SEED:      seed_words(s);
            xs256_pkg::ACT_JUMP:      jump_words(xs256_pkg::JUMP_POLY);
            xs256_pkg::ACT_LONG_JUMP: jump_words(xs256_pkg::LONG_JUMP_POLY);
            default:                  ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Idling helpers
    // ------------------------------------------------------------------
    function automatic bit roll(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic int sender_pct(input idle_mode_t m);
        case (m)
            IDLE_SENDER: return 63;
            IDLE_BOTH:   return 22;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_pct(input idle_mode_t m);
        case (m)
            IDLE_RECEIVER: return 63;
            IDLE_BOTH:     return 22;
            default:       return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: model update on acceptance, then present the next request
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            action     <= xs256_pkg::ACT_NEXT;
            seed_value <= '0;
            idle_mode  <= IDLE_NONE;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_action(action, seed_value);
            if (!in_valid || !in_stall)
            begin
                if (request_queue.size() != 0
                    && !(request_queue[0].drain_first && pending_words.size() != 0)
                    && !roll(sender_pct(request_queue[0].mode)))
                begin
                    drv_req = request_queue.pop_front();
                    in_valid   <= 1'b1;
                    action     <= drv_req.act;
                    seed_value <= drv_req.seed;
                    idle_mode  <= drv_req.mode;
                end
                else
                begin
                    // payload is don't-care while idle
                    in_valid   <= 1'b0;
                    action     <= 2'($urandom_range(3, 0));
                    seed_value <= {$urandom, $urandom};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each output word with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected random_value, expected none, actual %h",
                             $realtime, random_value);
                end
                else
                begin
                    want_word = pending_words.pop_front();
                    words_checked++;
                    if (random_value !== want_word)
                    begin
                        err_count++;
                        $display("%0t: random_value mismatch, expected %h, actual %h",
                                 $realtime, want_word, random_value);
                    end
                end
            end
            out_stall <= roll(receiver_pct(idle_mode));
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d words outstanding",
                         $realtime, pending_words.size());
                $display("xoshiro256ss_generator regression: fail");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    function automatic void add_request(input logic [1:0] act, input logic [W-1:0] s,
                                        input idle_mode_t m, input bit drain);
        gen_request_t r;
        r.act = act;
        r.seed = s;
        r.mode = m;
        r.drain_first = drain;
        request_queue.push_back(r);
    endfunction

    function automatic logic [W-1:0] pick_seed();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(63, 0);
            3:       return xs256_pkg::SEED_MIX1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        idle_mode_t mode_seq[5];
        int         pick;
        logic [1:0] act;

        mode_seq = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};

        // Unseeded: all-zero state is a fixed point, jumps keep it zero
        add_request(xs256_pkg::ACT_NEXT, '1, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, {$urandom, $urandom}, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_JUMP, {$urandom, $urandom}, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_LONG_JUMP, '1, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, '0, IDLE_NONE, 1'b0);
        // Seed extremes, seeds that cancel a mix constant
        add_request(xs256_pkg::ACT_SEED, '0, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, '1, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, '0, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_SEED, '1, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, {$urandom, $urandom}, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_SEED, xs256_pkg::SEED_MIX1, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, '0, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_SEED, xs256_pkg::SEED_MIX2, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, '0, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_SEED, xs256_pkg::SEED_MIX3, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, '1, IDLE_NONE, 1'b0);
        // Jumps on a seeded state, back to back with next
        add_request(xs256_pkg::ACT_JUMP, '1, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, '0, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_LONG_JUMP, '0, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, '1, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_SEED, 64'h8000_0000_0000_0001, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_JUMP, '0, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_LONG_JUMP, '0, IDLE_NONE, 1'b0);
        add_request(xs256_pkg::ACT_NEXT, '0, IDLE_NONE, 1'b0);

        // Random phases; each opens after all words have drained
        for (int p = 0; p < 5; p++)
        begin
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 84)
                    act = xs256_pkg::ACT_NEXT;
                else if (pick < 92)
                    act = xs256_pkg::ACT_SEED;
                else if (pick < 96)
                    act = xs256_pkg::ACT_JUMP;
                else
                    act = xs256_pkg::ACT_LONG_JUMP;
                add_request(act,
                            (act == xs256_pkg::ACT_SEED) ? pick_seed() : {$urandom, $urandom},
                            mode_seq[p], i == 0 || roll(1));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // sample on the falling edge so driver and monitor updates have settled
        while (request_queue.size() != 0 || in_valid)
            @(negedge clk);
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d next, %0d seed, %0d jump and %0d long jump transactions;",
                 action_count[xs256_pkg::ACT_NEXT], action_count[xs256_pkg::ACT_SEED],
                 action_count[xs256_pkg::ACT_JUMP], action_count[xs256_pkg::ACT_LONG_JUMP]);
        $display("%0d output words checked, %0d errors.", words_checked, err_count);
        if (err_count == 0)
            $display("xoshiro256ss_generator regression: pass");
        else
            $display("xoshiro256ss_generator regression: fail");
        $finish;
    end

endmodule : tb_xoshiro256ss_generator

`default_nettype wire
